>>> design/matrix_multiply_engine_macros.svh
// Assertion macros for the matrix multiply engine.
`ifndef MATRIX_MULTIPLY_ENGINE_MACROS_SVH
`define MATRIX_MULTIPLY_ENGINE_MACROS_SVH
`ifndef SYNTH
`define MME_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define MME_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define MME_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define MME_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

>>> design/mme_pkg.sv
// Shared types, constants and helpers of the matrix multiply engine.
package mme_pkg;
   localparam int MAX_DIM_DEF    = 8;
   localparam int ELEM_WIDTH_DEF = 16;
   localparam int SUM_W          = 35;
   localparam int IDX_PORT_W     = 3;
   localparam int DIM_W          = 4;
   localparam int CSR_IDX_W      = 2;

   typedef enum logic [1:0] {
      ACT_WR_A    = 2'd0,
      ACT_WR_B    = 2'd1,
      ACT_COMPUTE = 2'd2,
      ACT_NOP     = 2'd3
   } action_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ROW_COUNT   = 2'd0,
      REG_INNER_COUNT = 2'd1,
      REG_COL_COUNT   = 2'd2,
      REG_NONE        = 2'd3
   } reg_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MAC,
      ST_FLUSH,
      ST_DRAIN
   } state_type;

   typedef struct packed {
      logic                  clear;
      logic                  mul_en;
      logic                  acc_en;
      logic                  load;
      logic                  shift;
      logic [IDX_PORT_W-1:0] sel;
   } cell_ctrl_type;

   typedef struct packed {
      logic                  we;
      logic [IDX_PORT_W-1:0] row;
      logic [IDX_PORT_W-1:0] col;
   } bwrite_type;

   // dimension minus one, with 0 taken as 1 and anything above the maximum as the maximum
   function automatic logic [IDX_PORT_W-1:0] clamp_dm1(input logic [DIM_W-1:0] d,
                                                      input int maxd);
      logic [DIM_W-1:0] r;
      begin
         if (d == '0) begin
            r = '0;
         end else if (d > DIM_W'(maxd)) begin
            r = DIM_W'(maxd - 1);
         end else begin
            r = d - DIM_W'(1);
         end
         return r[IDX_PORT_W-1:0];
      end
   endfunction
endpackage

>>> design/mme_ifs.sv
// Channel interfaces: element/compute requests, C results, register writes.
interface mme_req_if import mme_pkg::*; #(parameter int ELEM_WIDTH = ELEM_WIDTH_DEF);
   logic                         valid;
   logic                         ready;
   logic [1:0]                   action;
   logic [IDX_PORT_W-1:0]        row;
   logic [IDX_PORT_W-1:0]        col;
   logic signed [ELEM_WIDTH-1:0] value;
   modport source (output valid, action, row, col, value, input ready);
   modport sink (input valid, action, row, col, value, output ready);
endinterface

interface mme_rsp_if import mme_pkg::*;;
   logic                    valid;
   logic                    ready;
   logic [IDX_PORT_W-1:0]   out_row;
   logic [IDX_PORT_W-1:0]   out_col;
   logic signed [SUM_W-1:0] sum;
   logic                    last;
   modport source (output valid, out_row, out_col, sum, last, input ready);
   modport sink (input valid, out_row, out_col, sum, last, output ready);
endinterface

interface mme_csr_if import mme_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [DIM_W-1:0]     data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

>>> design/mme_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mme_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_ff;
endmodule

>>> design/mme_cell.sv
// One column cell: holds a column of B, accumulates one C element, shifts results out.
module mme_cell import mme_pkg::*; #(
   parameter int ELEM_WIDTH = ELEM_WIDTH_DEF,
   parameter int MAX_DIM    = MAX_DIM_DEF,
   parameter int COL        = 0
) (
   input  logic                         clock,
   input  logic                         reset,
   input  cell_ctrl_type                ctrl,
   input  bwrite_type                   bw,
   input  logic signed [ELEM_WIDTH-1:0] b_value,
   input  logic signed [ELEM_WIDTH-1:0] a_value,
   input  logic signed [SUM_W-1:0]      chain_in,
   output logic signed [SUM_W-1:0]      chain_out
);
   localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int NB    = 1 << IDX_W;

   logic signed [ELEM_WIDTH-1:0]   b_ff [NB];
   logic signed [SUM_W-1:0]        prod_ff, acc_ff, out_ff;
   logic signed [2*ELEM_WIDTH-1:0] prod_full;
   logic                           hit;

   assign hit       = bw.we && (bw.col == IDX_PORT_W'(COL));
   assign prod_full = a_value * b_ff[ctrl.sel[IDX_W-1:0]];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < NB; r++) begin
            b_ff[r] <= '0;
         end
      end else if (hit) begin
         b_ff[bw.row[IDX_W-1:0]] <= b_value;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.mul_en) begin
         prod_ff <= SUM_W'(prod_full);
      end
      if (ctrl.clear) begin
         acc_ff <= '0;
      end else if (ctrl.acc_en) begin
         acc_ff <= acc_ff + prod_ff;
      end
      if (ctrl.load) begin
         out_ff <= acc_ff;
      end else if (ctrl.shift) begin
         out_ff <= chain_in;
      end
   end

   assign chain_out = out_ff;
endmodule

>>> design/matrix_multiply_engine.sv
// Top level: C = A x B on a row of column cells, A in RAM, B held in the cells.
//  channel  dir  handshake          payload
//  req_chan in   valid/ready        action, row, col, value
//  rsp_chan out  valid/ready        out_row, out_col, sum, last
//  csr_chan in   valid/ready (=1)   index, data
// A load beat is written straight into the A RAM or the B cells. A compute runs row by row:
// k MAC reads issued from the A RAM read port, a pipeline flush, then n result beats,
// with stalls on rsp_chan.ready; req_chan is held off meanwhile.
// Synchronous reset zeroes A (valid bits) and B and sets all dimensions to 8.
module matrix_multiply_engine import mme_pkg::*; #(
   parameter int MAX_DIM    = MAX_DIM_DEF,
   parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
   input logic clock,
   input logic reset,
   mme_req_if.sink   req_chan,
   mme_rsp_if.source rsp_chan,
   mme_csr_if.sink   csr_chan
);
`include "matrix_multiply_engine_macros.svh"
   localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int NA    = 1 << (2 * IDX_W);

   state_type            state_ff, state_in;
   logic [DIM_W-1:0]     rows_ff, inner_ff, cols_ff;
   logic [IDX_W-1:0]     i_ff, i_in, t_ff, t_in, j_ff, j_in;
   logic [IDX_W-1:0]     mdm1, kdm1, ndm1;
   logic                 rd_v_ff, prod_v_ff, av_ff;
   logic [IDX_W-1:0]     rd_t_ff;
   logic [NA-1:0]        a_valid_ff;
   logic                 req_acc, in_range, a_we;
   logic [2*IDX_W-1:0]   wr_addr, rd_addr;
   logic [ELEM_WIDTH-1:0] ram_q;
   logic signed [ELEM_WIDTH-1:0] a_value;
   cell_ctrl_type        ctrl;
   bwrite_type           bw;
   logic signed [SUM_W-1:0] chain [MAX_DIM+1];
   logic [IDX_PORT_W-1:0] m_full, k_full, n_full;

   assign m_full = clamp_dm1(rows_ff, MAX_DIM);
   assign k_full = clamp_dm1(inner_ff, MAX_DIM);
   assign n_full = clamp_dm1(cols_ff, MAX_DIM);
   assign mdm1   = m_full[IDX_W-1:0];
   assign kdm1   = k_full[IDX_W-1:0];
   assign ndm1   = n_full[IDX_W-1:0];

   // configuration
   assign csr_chan.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff  <= DIM_W'(8);
         inner_ff <= DIM_W'(8);
         cols_ff  <= DIM_W'(8);
      end else if (csr_chan.valid) begin
         unique case (reg_index_type'(csr_chan.index))
            REG_ROW_COUNT:   rows_ff  <= csr_chan.data;
            REG_INNER_COUNT: inner_ff <= csr_chan.data;
            REG_COL_COUNT:   cols_ff  <= csr_chan.data;
            default: ;
         endcase
      end
   end

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_acc  = req_chan.valid && req_chan.ready;
   assign in_range = ({1'b0, req_chan.row} < DIM_W'(MAX_DIM))
                  && ({1'b0, req_chan.col} < DIM_W'(MAX_DIM));
   assign a_we     = req_acc && in_range && (action_type'(req_chan.action) == ACT_WR_A);
   assign wr_addr  = {req_chan.row[IDX_W-1:0], req_chan.col[IDX_W-1:0]};
   assign rd_addr  = {i_ff, t_ff};

   assign bw.we  = req_acc && in_range && (action_type'(req_chan.action) == ACT_WR_B);
   assign bw.row = req_chan.row;
   assign bw.col = req_chan.col;

   mme_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(NA)) u_a_ram (
      .clock   (clock),
      .wr_en   (a_we),
      .wr_addr (wr_addr),
      .wr_data (req_chan.value),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   // never-written A entries read as zero
   assign a_value = av_ff ? $signed(ram_q) : '0;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_acc && action_type'(req_chan.action) == ACT_COMPUTE) begin
            state_in = ST_MAC;
         end
         ST_MAC:   if (t_ff == kdm1) begin
            state_in = ST_FLUSH;
         end
         ST_FLUSH: if (!rd_v_ff && !prod_v_ff) begin
            state_in = ST_DRAIN;
         end
         ST_DRAIN: if (rsp_chan.ready && j_ff == ndm1) begin
            state_in = (i_ff == mdm1) ? ST_IDLE : ST_MAC;
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs and counters
   always_comb begin
      i_in        = i_ff;
      t_in        = t_ff;
      j_in        = j_ff;
      ctrl.clear  = 1'b0;
      ctrl.load   = 1'b0;
      ctrl.shift  = 1'b0;
      ctrl.mul_en = rd_v_ff;
      ctrl.acc_en = prod_v_ff;
      ctrl.sel    = IDX_PORT_W'(rd_t_ff);
      unique case (state_ff)
         ST_IDLE: begin
            i_in       = '0;
            t_in       = '0;
            ctrl.clear = 1'b1;
         end
         ST_MAC: begin
            t_in = (t_ff == kdm1) ? '0 : t_ff + IDX_W'(1);
         end
         ST_FLUSH: begin
            if (!rd_v_ff && !prod_v_ff) begin
               ctrl.load = 1'b1;
               j_in      = '0;
            end
         end
         ST_DRAIN: begin
            if (rsp_chan.ready) begin
               ctrl.shift = 1'b1;
               j_in       = j_ff + IDX_W'(1);
               if (j_ff == ndm1) begin
                  i_in       = i_ff + IDX_W'(1);
                  ctrl.clear = 1'b1;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         rd_v_ff    <= 1'b0;
         prod_v_ff  <= 1'b0;
         a_valid_ff <= '0;
      end else begin
         state_ff  <= state_in;
         rd_v_ff   <= (state_ff == ST_MAC);
         prod_v_ff <= rd_v_ff;
         if (a_we) begin
            a_valid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      i_ff    <= i_in;
      t_ff    <= t_in;
      j_ff    <= j_in;
      rd_t_ff <= t_ff;
      av_ff   <= a_valid_ff[rd_addr];
   end

   assign chain[MAX_DIM] = '0;
   for (genvar c = 0; c < MAX_DIM; c++) begin : g_cell
      mme_cell #(.ELEM_WIDTH(ELEM_WIDTH), .MAX_DIM(MAX_DIM), .COL(c)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .bw        (bw),
         .b_value   (req_chan.value),
         .a_value   (a_value),
         .chain_in  (chain[c+1]),
         .chain_out (chain[c])
      );
   end

   assign rsp_chan.valid   = (state_ff == ST_DRAIN);
   assign rsp_chan.out_row = IDX_PORT_W'(i_ff);
   assign rsp_chan.out_col = IDX_PORT_W'(j_ff);
   assign rsp_chan.sum     = chain[0];
   assign rsp_chan.last    = (i_ff == mdm1) && (j_ff == ndm1);

   `MME_ASSERT_NOW(a_no_req_while_rsp, clock, reset, rsp_chan.valid, !req_chan.ready)
   `MME_ASSERT_NEXT(a_idle_after_last, clock, reset,
      rsp_chan.valid && rsp_chan.ready && rsp_chan.last, req_chan.ready)
   `MME_ASSERT_NOW(a_pipe_empty_drain, clock, reset, state_ff == ST_DRAIN,
      !rd_v_ff && !prod_v_ff)
endmodule
